>>> rtl/core/pe_pkg.sv
// package with shared types and constants for the polynomial evaluator
`default_nettype none

package pe_pkg;

    localparam int MAX_DEGREE  = 6;
    localparam int NUM_COEFF   = 7;
    localparam int NUM_STAGES  = MAX_DEGREE + 1;
    localparam int DATA_W      = 32;
    localparam int DEG_W       = 4;
    localparam int REG_IDX_W   = 3;
    localparam int COEFF_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_DEGREE  = 3'd0,
        REG_COEFF_0 = 3'd1,
        REG_COEFF_1 = 3'd2,
        REG_COEFF_2 = 3'd3,
        REG_COEFF_3 = 3'd4,
        REG_COEFF_4 = 3'd5,
        REG_COEFF_5 = 3'd6,
        REG_COEFF_6 = 3'd7
    } reg_idx_t;

    typedef logic [DATA_W-1:0] word_t;

    typedef word_t [MAX_DEGREE:0] coeff_vec_t;

    typedef struct packed {
        word_t x;
        word_t acc;
    } stage_data_t;

endpackage

`default_nettype wire

>>> rtl/core/pe_cfg_regs.sv
// configuration registers and degree masking of the coefficients
`default_nettype none

module pe_cfg_regs
    import pe_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [REG_IDX_W-1:0] wr_index,
    input  wire logic [DATA_W-1:0]    wr_data,
    output coeff_vec_t                coeff_used
);

    logic [DEG_W-1:0] degree_reg;
    word_t            coeff_reg [NUM_COEFF];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= {DEG_W{1'b1}};
            for (int i = 0; i < NUM_COEFF; i++)
            begin
                coeff_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            if (wr_index == REG_DEGREE)
            begin
                degree_reg <= wr_data[DEG_W-1:0];
            end
            else
            begin
                coeff_reg[REG_IDX_W'(wr_index - REG_IDX_W'(1))] <= wr_data;
            end
        end
    end

    // negative degree masks every term, degrees above the maximum saturate naturally
    always_comb
    begin
        for (int i = 0; i <= MAX_DEGREE; i++)
        begin
            if (!degree_reg[DEG_W-1] && (COEFF_IDX_W'(i) <= degree_reg[DEG_W-2:0]))
            begin
                coeff_used[i] = coeff_reg[i];
            end
            else
            begin
                coeff_used[i] = '0;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/pe_horner_stage.sv
// one registered multiply-add step of the horner chain
`default_nettype none

module pe_horner_stage
    import pe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        up_valid,
    input  wire stage_data_t up_data,
    input  wire word_t       coeff,
    input  wire logic        down_ready,
    output logic             ready,
    output logic             valid,
    output stage_data_t      data
);

    logic        valid_reg;
    stage_data_t data_reg;
    stage_data_t data_next;
    word_t       product;

    assign ready = !valid_reg || down_ready;

    always_comb
    begin
        product        = DATA_W'(up_data.acc * up_data.x);
        data_next.x    = up_data.x;
        data_next.acc  = DATA_W'(product + coeff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

`default_nettype wire

>>> rtl/core/polynomial_evaluator_core.sv
// top level of the pipelined polynomial evaluator
//
// evaluates coeff_0 + coeff_1*x + ... + coeff_d*x^d modulo 2^32 for each point
// input channel: in_valid / in_stall with point; a transaction completes when
//   in_valid is high and in_stall is low
// output channel: out_valid / out_stall with poly_value, same rule
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0 is
//   the degree, indexes 1 to 7 are coeff_0 to coeff_6; cfg_ready is always high
// one horner multiply-add per stage, MAX_DEGREE + 1 stages (poly_value is on the
//   output register of the last stage)
// throughput is one point per cycle while out_stall is low; the stage multiplier sets the cycle time
// each stage holds its item while the next one is full and stalled, so empty
//   stages still take new points while out_stall is high
// reset empties the pipeline, sets degree to -1 and every coefficient to 0;
//   a degree of -1 or below yields 0
`default_nettype none

module polynomial_evaluator_core
    import pe_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [DATA_W-1:0]    point,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [DATA_W-1:0]         poly_value,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data
);

    coeff_vec_t          coeff_used;
    logic [NUM_STAGES:0] stage_ready;
    logic                stage_valid [NUM_STAGES];
    stage_data_t         stage_data  [NUM_STAGES];
    stage_data_t         first_data;

    assign cfg_ready = 1'b1;

    pe_cfg_regs u_cfg_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (cfg_valid && cfg_ready),
        .wr_index   (cfg_index),
        .wr_data    (cfg_data),
        .coeff_used (coeff_used)
    );

    assign first_data.x   = point;
    assign first_data.acc = '0;

    assign stage_ready[NUM_STAGES] = !out_stall;

    for (genvar k = 0; k < NUM_STAGES; k++)
    begin : g_stage
        if (k == 0)
        begin : g_first
            pe_horner_stage u_stage (
                .clk        (clk),
                .rst_n      (rst_n),
                .up_valid   (in_valid),
                .up_data    (first_data),
                .coeff      (coeff_used[MAX_DEGREE]),
                .down_ready (stage_ready[1]),
                .ready      (stage_ready[0]),
                .valid      (stage_valid[0]),
                .data       (stage_data[0])
            );
        end
        else
        begin : g_next
            pe_horner_stage u_stage (
                .clk        (clk),
                .rst_n      (rst_n),
                .up_valid   (stage_valid[k-1]),
                .up_data    (stage_data[k-1]),
                .coeff      (coeff_used[MAX_DEGREE-k]),
                .down_ready (stage_ready[k+1]),
                .ready      (stage_ready[k]),
                .valid      (stage_valid[k]),
                .data       (stage_data[k])
            );
        end
    end

    assign in_stall   = !stage_ready[0];
    assign out_valid  = stage_valid[NUM_STAGES-1];
    assign poly_value = stage_data[NUM_STAGES-1].acc;

    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> stage_valid[0]
    ) else $error("input stalled with an empty first stage");

    a_input_captured: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> stage_valid[0]
    ) else $error("accepted transaction not held in the first stage");

    a_stage_advance: assert property (
        @(posedge clk) disable iff (!rst_n)
        (stage_valid[0] && stage_ready[1]) |=> stage_valid[1]
    ) else $error("item lost between the first and second stage");

    a_hold_when_blocked: assert property (
        @(posedge clk) disable iff (!rst_n)
        (stage_valid[NUM_STAGES-2] && !stage_ready[NUM_STAGES-1]) |=>
            (stage_valid[NUM_STAGES-2] && $stable(stage_data[NUM_STAGES-2]))
    ) else $error("blocked stage dropped or changed its item");

endmodule

`default_nettype wire
